/* design/raster_shape_drawing_engine_core_defines.svh */
// Assertion shorthands shared by the checkers of the drawing engine.
`ifndef RASTER_SHAPE_DRAWING_ENGINE_CORE_DEFINES_SVH
`define RASTER_SHAPE_DRAWING_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define RSDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define RSDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rsde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rsde_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int XB          = $clog2(MAX_WIDTH);
	localparam int YB          = $clog2(MAX_HEIGHT);
	localparam int COLOUR_W    = 24;
	localparam int DIM_W       = 8;
	localparam int PROD_W      = YB + DIM_W;
	localparam int POS_W       = 10;
	localparam int EXT_W       = 9;
	localparam int COORD_W     = 12;
	localparam int D_W         = 14;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(128);

	// register select is the word index of the byte address
	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	// midpoint circle decision terms
	localparam logic signed [D_W-1:0] CIRC_D_INIT   = D_W'(3);
	localparam logic signed [D_W-1:0] CIRC_INC_DIAG = D_W'(10);
	localparam logic signed [D_W-1:0] CIRC_INC_AXIS = D_W'(6);

	typedef enum logic [2:0] {
		FUNC_CLEAR  = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_READ   = 3'd2,
		FUNC_RECT   = 3'd3,
		FUNC_CIRCLE = 3'd4
	} func_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic   valid;
		logic   last;
		logic   wr;
		logic   rd;
		coord_t x;
		coord_t y;
	} point_t;

	typedef enum logic [1:0] {
		ENG_INIT,
		ENG_IDLE,
		ENG_FILL,
		ENG_DRAW
	} eng_state_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_RECT,
		GEN_CIRC
	} gen_mode_t;

	typedef enum logic [1:0] {
		EDGE_TOP,
		EDGE_BOTTOM,
		EDGE_LEFT,
		EDGE_RIGHT
	} edge_t;

endpackage
`default_nettype wire

/* design/rsde_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module rsde_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* design/rsde_shape_gen.sv */
`timescale 1ns / 1ps
`default_nettype none
module rsde_shape_gen (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire logic [2:0]                          func,
	input  wire logic signed [rsde_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [rsde_pkg::POS_W-1:0]   pos_y,
	input  wire logic [rsde_pkg::EXT_W-1:0]          extent_a,
	input  wire logic [rsde_pkg::EXT_W-1:0]          extent_b,
	output rsde_pkg::point_t                         pt
);
	import rsde_pkg::*;

	gen_mode_t mode_q, mode_d;
	edge_t     edge_q, edge_d;
	logic [EXT_W-1:0] idx_q, idx_d, w_q, w_d, h_q, h_d, lim;
	coord_t    ox_q, ox_d, oy_q, oy_d;
	logic signed [EXT_W+1:0] px_q, px_d, py_q, py_d, px1, py1;
	logic signed [D_W-1:0]   d_q, d_d, d1, diff_d;
	logic [2:0] oct_q, oct_d;
	point_t     pt_q, pt_d;
	coord_t     pxc, pyc, idxc, wc, hc;

	assign pxc  = coord_t'(px_q);
	assign pyc  = coord_t'(py_q);
	assign idxc = coord_t'(idx_q);
	assign wc   = coord_t'(w_q);
	assign hc   = coord_t'(h_q);
	assign lim  = (edge_q == EDGE_LEFT || edge_q == EDGE_RIGHT) ? h_q : w_q;

	// next circle step, used after the eighth point of each step
	always_comb begin
		px1    = px_q + (EXT_W+2)'(1);
		py1    = py_q;
		diff_d = '0;
		if (d_q > 0) begin
			py1    = py_q - (EXT_W+2)'(1);
			diff_d = D_W'(px1) - D_W'(py1);
			d1     = d_q + (diff_d <<< 2) + CIRC_INC_DIAG;
		end else begin
			d1 = d_q + (D_W'(px1) <<< 2) + CIRC_INC_AXIS;
		end
	end

	always_comb begin
		mode_d = mode_q;
		edge_d = edge_q;
		idx_d  = idx_q;
		w_d    = w_q;
		h_d    = h_q;
		ox_d   = ox_q;
		oy_d   = oy_q;
		px_d   = px_q;
		py_d   = py_q;
		d_d    = d_q;
		oct_d  = oct_q;
		pt_d   = '0;
		unique case (mode_q)
			GEN_IDLE: begin
				if (go) begin
					ox_d = coord_t'(pos_x);
					oy_d = coord_t'(pos_y);
					unique case (func)
						FUNC_CLEAR: begin
						end
						FUNC_WRITE, FUNC_READ: begin
							pt_d.valid = 1'b1;
							pt_d.last  = 1'b1;
							pt_d.wr    = (func == FUNC_WRITE);
							pt_d.rd    = (func == FUNC_READ);
							pt_d.x     = coord_t'(pos_x);
							pt_d.y     = coord_t'(pos_y);
						end
						FUNC_RECT: begin
							w_d    = extent_a;
							h_d    = extent_b;
							idx_d  = '0;
							edge_d = EDGE_TOP;
							mode_d = GEN_RECT;
						end
						FUNC_CIRCLE: begin
							px_d   = '0;
							py_d   = (EXT_W+2)'(extent_a);
							d_d    = CIRC_D_INIT - (D_W'(extent_a) <<< 1);
							oct_d  = '0;
							mode_d = GEN_CIRC;
						end
						default: begin
							// unknown operation: send a bare token for the result
							pt_d.valid = 1'b1;
							pt_d.last  = 1'b1;
						end
					endcase
				end
			end
			GEN_RECT: begin
				pt_d.valid = 1'b1;
				pt_d.wr    = 1'b1;
				pt_d.last  = (edge_q == EDGE_RIGHT) && (idx_q == lim);
				unique case (edge_q)
					EDGE_TOP: begin
						pt_d.x = ox_q + idxc;
						pt_d.y = oy_q;
					end
					EDGE_BOTTOM: begin
						pt_d.x = ox_q + idxc;
						pt_d.y = oy_q + hc;
					end
					EDGE_LEFT: begin
						pt_d.x = ox_q;
						pt_d.y = oy_q + idxc;
					end
					EDGE_RIGHT: begin
						pt_d.x = ox_q + wc;
						pt_d.y = oy_q + idxc;
					end
					default: begin
					end
				endcase
				if (idx_q == lim) begin
					idx_d  = '0;
					edge_d = edge_t'(edge_q + 2'd1);
					if (edge_q == EDGE_RIGHT) begin
						mode_d = GEN_IDLE;
					end
				end else begin
					idx_d = idx_q + EXT_W'(1);
				end
			end
			GEN_CIRC: begin
				pt_d.valid = 1'b1;
				pt_d.wr    = 1'b1;
				unique case (oct_q)
					3'd0: begin pt_d.x = ox_q + pxc; pt_d.y = oy_q + pyc; end
					3'd1: begin pt_d.x = ox_q - pxc; pt_d.y = oy_q + pyc; end
					3'd2: begin pt_d.x = ox_q + pxc; pt_d.y = oy_q - pyc; end
					3'd3: begin pt_d.x = ox_q - pxc; pt_d.y = oy_q - pyc; end
					3'd4: begin pt_d.x = ox_q + pyc; pt_d.y = oy_q + pxc; end
					3'd5: begin pt_d.x = ox_q - pyc; pt_d.y = oy_q + pxc; end
					3'd6: begin pt_d.x = ox_q + pyc; pt_d.y = oy_q - pxc; end
					3'd7: begin pt_d.x = ox_q - pyc; pt_d.y = oy_q - pxc; end
					default: begin
					end
				endcase
				oct_d = oct_q + 3'd1;
				if (oct_q == 3'd7) begin
					px_d = px1;
					py_d = py1;
					d_d  = d1;
					if (py1 < px1) begin
						pt_d.last = 1'b1;
						mode_d    = GEN_IDLE;
					end
				end
			end
			default: begin
				mode_d = GEN_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= GEN_IDLE;
			pt_q   <= '0;
		end else begin
			mode_q <= mode_d;
			pt_q   <= pt_d;
		end
	end

	always_ff @(posedge clk) begin
		edge_q <= edge_d;
		idx_q  <= idx_d;
		w_q    <= w_d;
		h_q    <= h_d;
		ox_q   <= ox_d;
		oy_q   <= oy_d;
		px_q   <= px_d;
		py_q   <= py_d;
		d_q    <= d_d;
		oct_q  <= oct_d;
	end

	assign pt = pt_q;

endmodule
`default_nettype wire

/* design/raster_shape_drawing_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Write, read or unknown operation: result passes pt_q, stage 1, stage 2 and the result register.
// Rectangle: 2*(w+1) + 2*(h+1) pixels; circle: eight pixels per midpoint step (one pixel/cycle).
// Clear: every frame store entry is written, one per cycle through its single port.
// Throughput: one request at a time; busy stays high until the result strobe (done).
// Reset: a clearing pass zeroes every frame store entry; busy is high throughout.
// The result strobe cannot be stalled: read_colour and inside_res are valid for the done cycle only.
module raster_shape_drawing_engine_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command request
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [2:0]                          func,
	input  wire logic signed [rsde_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [rsde_pkg::POS_W-1:0]   pos_y,
	input  wire logic [rsde_pkg::EXT_W-1:0]          extent_a,
	input  wire logic [rsde_pkg::EXT_W-1:0]          extent_b,
	input  wire logic [rsde_pkg::COLOUR_W-1:0]       colour,
	// result
	output logic                                     done,
	output logic [rsde_pkg::COLOUR_W-1:0]            read_colour,
	output logic                                     inside_res,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rsde_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [rsde_pkg::PDATA_W-1:0]        pwdata,
	output logic [rsde_pkg::PDATA_W-1:0]             prdata,
	output logic                                     pready
);
	import rsde_pkg::*;

	eng_state_t state_q, state_d;

	logic [DIM_W-1:0]    width_q, height_q, effw, effh;
	logic [COLOUR_W-1:0] colour_q;
	logic [ADDR_W-1:0]   fill_cnt_q;
	logic                fill_end, fill_finish, go, cfg_wr, reg_sel;

	point_t              pt;
	coord_t              effw_c, effh_c;
	logic                pt_inside;
	logic [PROD_W-1:0]   pt_prod;

	logic                valid_s1, last_s1, wr_s1, rd_s1, inside_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                last_s2, rdok_s2;

	logic                ram_en, ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [COLOUR_W-1:0] ram_wdata, ram_rdata;

	logic                done_q, inside_q;
	logic [COLOUR_W-1:0] read_colour_q;

	// ---------------------------------------------------------------
	// Configuration registers: the word index alone selects the register.
	// ---------------------------------------------------------------
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == REG_IDX_HEIGHT) ? PDATA_W'(height_q) : PDATA_W'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_IDX_WIDTH) begin
				width_q <= pwdata[DIM_W-1:0];
			end else begin
				height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	// Clamp the image size to the frame store; zero leaves nothing inside.
	assign effw = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
	assign effh = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;

	// ---------------------------------------------------------------
	// Sequencer: clearing pass, fill sweep, or pixel stream through the
	// address stage.
	// ---------------------------------------------------------------
	assign fill_end    = (fill_cnt_q == ADDR_W'(STORE_DEPTH - 1));
	assign fill_finish = (state_q == ENG_FILL) && fill_end;

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		go      = 1'b0;
		unique case (state_q)
			ENG_INIT: begin
				if (fill_end) begin
					state_d = ENG_IDLE;
				end
			end
			ENG_IDLE: begin
				busy = 1'b0;
				go   = start;
				if (start) begin
					state_d = (func == FUNC_CLEAR) ? ENG_FILL : ENG_DRAW;
				end
			end
			ENG_FILL: begin
				if (fill_end) begin
					state_d = ENG_IDLE;
				end
			end
			ENG_DRAW: begin
				// drop busy as the final pixel leaves the pipeline
				if (last_s2) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ENG_INIT;
			fill_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			// advance the sweep address in both clearing modes, wrap to zero at the end
			if (state_q == ENG_INIT || state_q == ENG_FILL) begin
				fill_cnt_q <= fill_end ? '0 : fill_cnt_q + ADDR_W'(1);
			end
		end
	end

	// hold the request colour for the whole command
	always_ff @(posedge clk) begin
		if (go) begin
			colour_q <= colour;
		end
	end

	// ---------------------------------------------------------------
	// Pixel source: single pixels, rectangle edges and circle octants.
	// ---------------------------------------------------------------
	rsde_shape_gen u_shape_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.func     (func),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.extent_a (extent_a),
		.extent_b (extent_b),
		.pt       (pt)
	);

	// ---------------------------------------------------------------
	// Address stage: clip against the image and form y*W + x.
	// ---------------------------------------------------------------
	assign effw_c    = coord_t'(effw);
	assign effh_c    = coord_t'(effh);
	assign pt_inside = !pt.x[COORD_W-1] && (pt.x < effw_c) &&
	                   !pt.y[COORD_W-1] && (pt.y < effh_c);
	assign pt_prod   = PROD_W'(pt.y[YB-1:0]) * PROD_W'(effw) + PROD_W'(pt.x[XB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			wr_s1     <= 1'b0;
			rd_s1     <= 1'b0;
			inside_s1 <= 1'b0;
			last_s2   <= 1'b0;
			rdok_s2   <= 1'b0;
		end else begin
			valid_s1  <= pt.valid;
			last_s1   <= pt.valid && pt.last;
			wr_s1     <= pt.wr;
			rd_s1     <= pt.rd;
			inside_s1 <= pt_inside;
			last_s2   <= last_s1;
			rdok_s2   <= valid_s1 && rd_s1 && inside_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pt_prod[ADDR_W-1:0];
	end

	// ---------------------------------------------------------------
	// Frame store port: the sweep owns it while clearing, else stage 1.
	// ---------------------------------------------------------------
	always_comb begin
		if (state_q == ENG_INIT || state_q == ENG_FILL) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = fill_cnt_q;
			ram_wdata = (state_q == ENG_FILL) ? colour_q : '0;
		end else begin
			ram_en    = valid_s1 && inside_s1 && (wr_s1 || rd_s1);
			ram_we    = wr_s1;
			ram_addr  = addr_s1;
			ram_wdata = colour_q;
		end
	end

	rsde_ram #(
		.WIDTH (COLOUR_W),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// Result register: one strobe per command; read data only when a
	// read landed inside the image.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			done_q   <= last_s2 || fill_finish;
			inside_q <= rdok_s2;
		end
	end

	always_ff @(posedge clk) begin
		read_colour_q <= rdok_s2 ? ram_rdata : '0;
	end

	assign done        = done_q;
	assign inside_res  = inside_q;
	assign read_colour = read_colour_q;

endmodule
`default_nettype wire

/* design/rsde_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "raster_shape_drawing_engine_core_defines.svh"
module rsde_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic                               done,
	input wire logic [rsde_pkg::COLOUR_W-1:0]      read_colour,
	input wire logic                               inside_res
);

	`RSDE_ASSERT_IMP(a_outside_zero, clk, arst_n, done && !inside_res, read_colour == '0, "colour returned without an inside read")
	`RSDE_ASSERT_IMP(a_inside_strobed, clk, arst_n, inside_res, done, "inside flag outside the result strobe")
	`RSDE_ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy, "request taken but busy not raised")
	`RSDE_ASSERT_NXT(a_single_strobe, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`RSDE_ASSERT_IMP(a_strobe_after_busy, clk, arst_n, done, $past(busy), "result without a command in flight")

endmodule

bind raster_shape_drawing_engine_core rsde_checker u_rsde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.read_colour (read_colour),
	.inside_res  (inside_res)
);
`default_nettype wire

/* test/raster_shape_drawing_engine_core_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module raster_shape_drawing_engine_core_tb;

	import rsde_pkg::*;

	// One drawing request as presented on the command ports
	typedef struct {
		logic [2:0]              func;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [EXT_W-1:0]        extent_a;
		logic [EXT_W-1:0]        extent_b;
		logic [COLOUR_W-1:0]     colour;
	} command_t;

	// What the done strobe must carry for one request
	typedef struct {
		logic [COLOUR_W-1:0] colour;
		logic                in_image;
	} result_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      start    = 1'b0;
	logic                      busy;
	logic [2:0]                func     = '0;
	logic signed [POS_W-1:0]   pos_x    = '0;
	logic signed [POS_W-1:0]   pos_y    = '0;
	logic [EXT_W-1:0]          extent_a = '0;
	logic [EXT_W-1:0]          extent_b = '0;
	logic [COLOUR_W-1:0]       colour   = '0;
	logic                      done;
	logic [COLOUR_W-1:0]       read_colour;
	logic                      inside_res;
	logic                      psel     = 1'b0;
	logic                      penable  = 1'b0;
	logic                      pwrite   = 1'b0;
	logic [PADDR_W-1:0]        paddr    = '0;
	logic [PDATA_W-1:0]        pwdata   = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	// Shadow copy of the frame store and the size registers
	logic [COLOUR_W-1:0] pixels [STORE_DEPTH];
	logic [DIM_W-1:0]    cfg_width  = SIZE_RESET;
	logic [DIM_W-1:0]    cfg_height = SIZE_RESET;

	command_t cmd_backlog [$];   // requests not yet presented
	result_t  due_results [$];   // results owed by the engine, oldest first
	int       recent_x [$];      // recently written pixels, to aim reads at
	int       recent_y [$];

	command_t cur_cmd;
	result_t  want;
	int       idle_pct   = 0;
	bit       drain_mode = 1'b0;
	int       errors     = 0;

	raster_shape_drawing_engine_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.extent_a    (extent_a),
		.extent_b    (extent_b),
		.colour      (colour),
		.done        (done),
		.read_colour (read_colour),
		.inside_res  (inside_res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Frame store predictor
	// ------------------------------------------------------------------

	// Size registers above the store limit act as the limit itself
	function automatic int active_w();
		return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
	endfunction

	function automatic int active_h();
		return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
	endfunction

	function automatic bit on_canvas(int x, int y);
		return x >= 0 && x < active_w() && y >= 0 && y < active_h();
	endfunction

	// Drop anything outside the active image; rows are packed at the active width
	function automatic void plot(int x, int y, logic [COLOUR_W-1:0] c);
		if (on_canvas(x, y))
			pixels[(y * active_w() + x) % STORE_DEPTH] = c;
	endfunction

	function automatic void trace_box(int x, int y, int w, int h, logic [COLOUR_W-1:0] c);
		for (int i = x; i <= x + w; i++) begin
			plot(i, y, c);
			plot(i, y + h, c);
		end
		for (int i = y; i <= y + h; i++) begin
			plot(x, i, c);
			plot(x + w, i, c);
		end
	endfunction

	// Midpoint circle, one octant walked and mirrored eight ways
	function automatic void trace_circle(int cx, int cy, int r, logic [COLOUR_W-1:0] c);
		int px;
		int py;
		int d;
		px = 0;
		py = r;
		d  = 3 - 2 * r;
		while (py >= px) begin
			plot(cx + px, cy + py, c);
			plot(cx - px, cy + py, c);
			plot(cx + px, cy - py, c);
			plot(cx - px, cy - py, c);
			plot(cx + py, cy + px, c);
			plot(cx - py, cy + px, c);
			plot(cx + py, cy - px, c);
			plot(cx - py, cy - px, c);
			px++;
			if (d > 0) begin
				py--;
				d = d + 4 * (px - py) + 10;
			end else begin
				d = d + 4 * px + 6;
			end
		end
	endfunction

	// Update the shadow store for one taken request and log what it owes
	function automatic void apply_command(command_t c);
		result_t r;
		int      x;
		int      y;
		x = c.pos_x;
		y = c.pos_y;
		r.colour   = '0;
		r.in_image = 1'b0;
		case (c.func)
			FUNC_CLEAR: begin
				foreach (pixels[i])
					pixels[i] = c.colour;
			end
			FUNC_WRITE: plot(x, y, c.colour);
			FUNC_READ: begin
				if (on_canvas(x, y)) begin
					r.colour   = pixels[(y * active_w() + x) % STORE_DEPTH];
					r.in_image = 1'b1;
				end
			end
			FUNC_RECT:   trace_box(x, y, int'(c.extent_a), int'(c.extent_b), c.colour);
			FUNC_CIRCLE: trace_circle(x, y, int'(c.extent_a), c.colour);
			default: ;
		endcase
		due_results.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	function automatic void queue_cmd(logic [2:0] f, int x, int y, int a, int b,
			logic [COLOUR_W-1:0] c);
		command_t cmd;
		cmd.func     = f;
		cmd.pos_x    = POS_W'(x);
		cmd.pos_y    = POS_W'(y);
		cmd.extent_a = EXT_W'(a);
		cmd.extent_b = EXT_W'(b);
		cmd.colour   = c;
		cmd_backlog.push_back(cmd);
	endfunction

	// Mostly just around the active image, now and then anywhere in the field
	function automatic logic signed [POS_W-1:0] pick_coord(int span);
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom_range(0, 1023));
		return POS_W'(int'($urandom_range(0, span + 15)) - 8);
	endfunction

	// Keep shapes small so the run stays short; a few reach the field limit
	function automatic logic [EXT_W-1:0] pick_extent();
		if ($urandom_range(0, 24) == 0)
			return EXT_W'($urandom_range(0, 511));
		return EXT_W'($urandom_range(0, 24));
	endfunction

	function automatic command_t make_cmd();
		command_t c;
		int       sel;
		int       k;
		sel        = $urandom_range(0, 999);
		c.pos_x    = pick_coord(active_w());
		c.pos_y    = pick_coord(active_h());
		c.extent_a = EXT_W'($urandom_range(0, 511));
		c.extent_b = EXT_W'($urandom_range(0, 511));
		c.colour   = COLOUR_W'($urandom());
		if (sel < 5) begin
			// full clears cost a whole store pass, so keep them rare
			c.func = FUNC_CLEAR;
		end else if (sel < 300) begin
			c.func = FUNC_WRITE;
			recent_x.push_back(int'(c.pos_x));
			recent_y.push_back(int'(c.pos_y));
			if (recent_x.size() > 16) begin
				void'(recent_x.pop_front());
				void'(recent_y.pop_front());
			end
		end else if (sel < 600) begin
			c.func = FUNC_READ;
			// aim half the reads at pixels written a short while ago
			if (recent_x.size() > 0 && $urandom_range(0, 1) == 1) begin
				k = $urandom_range(0, recent_x.size() - 1);
				c.pos_x = POS_W'(recent_x[k]);
				c.pos_y = POS_W'(recent_y[k]);
			end
		end else if (sel < 780) begin
			c.func     = FUNC_RECT;
			c.extent_a = pick_extent();
			c.extent_b = pick_extent();
		end else if (sel < 960) begin
			c.func     = FUNC_CIRCLE;
			c.extent_a = pick_extent();
		end else begin
			// codes beyond the last operation must do nothing
			c.func = 3'($urandom_range(int'(FUNC_CIRCLE) + 1, 7));
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Hold until every request is taken and answered, then give the engine
	// a margin and wait for busy to drop before touching the registers
	task automatic wait_quiet();
		while (cmd_backlog.size() != 0 || start || due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
	endtask

	// APB write: setup cycle, then access until pready; upper data bits are don't-care
	task automatic set_reg(logic idx, logic [DIM_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {PDATA_W'($urandom()) & ~PDATA_W'(8'hFF)} | PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_IDX_WIDTH)
			cfg_width = val;
		else
			cfg_height = val;
	endtask

	task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int idle, bit drain,
			int count);
		wait_quiet();
		set_reg(REG_IDX_WIDTH, w);
		set_reg(REG_IDX_HEIGHT, h);
		idle_pct   = idle;
		drain_mode = drain;
		recent_x.delete();
		recent_y.delete();
		repeat (count)
			cmd_backlog.push_back(make_cmd());
	endtask

	// ------------------------------------------------------------------
	// Driver: present requests from the backlog, hold each until taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// request taken at this edge: advance the predictor
			if (start && !busy)
				apply_command(cur_cmd);
			// while refused, hold the request as it stands
			if (!(start && busy)) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
						(!drain_mode || due_results.size() == 0)) begin
					cur_cmd  = cmd_backlog.pop_front();
					start    <= 1'b1;
					func     <= cur_cmd.func;
					pos_x    <= cur_cmd.pos_x;
					pos_y    <= cur_cmd.pos_y;
					extent_a <= cur_cmd.extent_a;
					extent_b <= cur_cmd.extent_b;
					colour   <= cur_cmd.colour;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each done strobe must match the oldest owed result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result read_colour %06h inside_res %0b", $time,
					read_colour, inside_res);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (read_colour !== want.colour) begin
					$display("%0t: read_colour expected %06h actual %06h", $time,
						want.colour, read_colour);
					errors++;
				end
				if (inside_res !== want.in_image) begin
					$display("%0t: inside_res expected %0b actual %0b", $time,
						want.in_image, inside_res);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		foreach (pixels[i])
			pixels[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// the engine zeroes its store after reset; hold off until it drops busy
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);

		// Directed requests at the reset size of 128 by 128
		idle_pct = 0;
		queue_cmd(FUNC_READ, 0, 0, 0, 0, '0);                    // untouched pixel reads zero
		queue_cmd(FUNC_WRITE, 0, 0, 0, 0, 24'hFFFFFF);
		queue_cmd(FUNC_READ, 0, 0, 511, 511, 24'h000000);
		queue_cmd(FUNC_WRITE, 127, 127, 0, 0, 24'h123456);        // far corner
		queue_cmd(FUNC_READ, 127, 127, 0, 0, '0);
		queue_cmd(FUNC_WRITE, -1, 0, 0, 0, 24'h0A0B0C);           // clipped left
		queue_cmd(FUNC_WRITE, 128, 3, 0, 0, 24'h0A0B0C);          // clipped right
		queue_cmd(FUNC_READ, -1, 0, 0, 0, '0);                    // outside reads zero
		queue_cmd(FUNC_READ, 128, 3, 0, 0, '0);
		queue_cmd(FUNC_READ, 3, 128, 0, 0, '0);
		queue_cmd(FUNC_READ, -512, 511, 0, 0, '0);
		queue_cmd(FUNC_RECT, 10, 10, 5, 3, 24'h00FF00);
		queue_cmd(FUNC_READ, 15, 13, 0, 0, '0);                   // far corner of the box
		queue_cmd(FUNC_READ, 12, 11, 0, 0, '0);                   // inside the outline
		queue_cmd(FUNC_RECT, -5, -5, 20, 20, 24'h0000FF);         // partly clipped box
		queue_cmd(FUNC_READ, 15, 0, 0, 0, '0);
		queue_cmd(FUNC_RECT, -512, -512, 511, 511, 24'hFF0000);   // wholly clipped
		queue_cmd(FUNC_RECT, 40, 40, 0, 0, 24'h808080);           // degenerate single pixel
		queue_cmd(FUNC_CIRCLE, 64, 64, 0, 0, 24'h00FFFF);         // zero radius
		queue_cmd(FUNC_READ, 64, 64, 0, 0, '0);
		queue_cmd(FUNC_CIRCLE, 0, 0, 10, 0, 24'hFF00FF);          // clipped at the origin
		queue_cmd(FUNC_READ, 10, 0, 0, 0, '0);
		queue_cmd(FUNC_CIRCLE, 511, -512, 511, 511, 24'h7F7F7F);  // largest radius
		queue_cmd(FUNC_CLEAR, 0, 0, 0, 0, 24'hA5A5A5);
		queue_cmd(FUNC_READ, 77, 33, 0, 0, '0);
		for (int f = int'(FUNC_CIRCLE) + 1; f <= 7; f++)
			queue_cmd(3'(f), 5, 5, 3, 3, 24'h5A5A5A);

		// Random phases over several image sizes and sender idling patterns
		run_phase(8'd128, 8'd128, 0, 1'b0, 300);
		run_phase(8'd37, 8'd90, 55, 1'b0, 250);
		// one request at a time: wait for each answer before the next
		run_phase(8'd1, 8'd128, 22, 1'b1, 100);
		run_phase(8'd255, 8'd200, 0, 1'b0, 150);   // sizes above the store limit
		run_phase(8'd0, 8'd255, 55, 1'b0, 50);     // zero width: nothing is inside
		run_phase(8'd64, 8'd1, 22, 1'b0, 150);

		wait_quiet();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest run this stimulus can produce
	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
